// ===== sv/tgsp_pkg.sv =====
// Shared types, codes and helpers of the tiled grid shortest path block.
package tgsp_pkg;

  // Geometry limits of the base grid and its tiling
  localparam int MAX_SIZE   = 32;
  localparam int MAX_TILES  = 5;

  // Fixed field widths
  localparam int COST_W     = 18;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int COORD_IN_W = 5;
  localparam int DIGIT_W    = 4;
  localparam int GS_CFG_W   = 6;
  localparam int TC_CFG_W   = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT = 2'd1;

  // Request command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_START,
    S_POP_CHECK,
    S_POP_RD,
    S_POP_FIRST,
    S_SIFT_RD,
    S_SIFT_WAIT,
    S_VIS_RD,
    S_VIS_CHK,
    S_NB_X,
    S_NB_Y,
    S_NB_EVAL,
    S_PUSH_LOOP,
    S_PUSH_WAIT,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load_cell;
    logic    run_start;
    logic    clr_step;
    logic    heap_init;
    logic    pop_issue;
    logic    pop_first;
    logic    sift_issue;
    logic    sift_move;
    logic    hole_place;
    logic    vis_issue;
    logic    vis_mark;
    logic    nb_first;
    logic    nb_next;
    logic    nb_x_eval;
    logic    nb_y_eval;
    logic    push_start;
    logic    push_issue;
    logic    push_move;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic heap_empty;
    logic heap_full;
    logic sift_has_child;
    logic sift_go;
    logic push_at_root;
    logic push_go;
    logic vis_hit;
    logic at_target;
    logic nb_ok;
    logic nb_last;
    logic out_free;
  } dp_stat_t;

  // ((v mod 9) + 1) for v up to 44
  function automatic logic [DIGIT_W-1:0] mod9_inc(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= 6'd9) r = r - 6'd9;
    end
    return DIGIT_W'(r) + 4'd1;
  endfunction

endpackage

// ===== sv/tgsp_ctrl.sv =====
// Search sequencer: state machine driving the shortest path datapath.
module tgsp_ctrl
  import tgsp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     cmd,
  input  dp_stat_t stat,
  output ctl_cmd_t ctl
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd == CMD_LOAD) begin
            ctl.load_cell = 1'b1;
          end else begin
            ctl.run_start = 1'b1;
            state_next    = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_START;
      end
      S_START: begin
        ctl.heap_init = 1'b1;
        state_next    = S_POP_CHECK;
      end
      S_POP_CHECK: begin
        if (stat.heap_empty) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = ST_EMPTY;
          state_next   = S_FINISH;
        end else begin
          state_next = S_POP_RD;
        end
      end
      S_POP_RD: begin
        ctl.pop_issue = 1'b1;
        state_next    = S_POP_FIRST;
      end
      S_POP_FIRST: begin
        ctl.pop_first = 1'b1;
        state_next    = S_SIFT_RD;
      end
      // sift the hole down from the root
      S_SIFT_RD: begin
        if (stat.sift_has_child) begin
          ctl.sift_issue = 1'b1;
          state_next     = S_SIFT_WAIT;
        end else begin
          ctl.hole_place = 1'b1;
          state_next     = S_VIS_RD;
        end
      end
      S_SIFT_WAIT: begin
        if (stat.sift_go) begin
          ctl.sift_move = 1'b1;
          state_next    = S_SIFT_RD;
        end else begin
          ctl.hole_place = 1'b1;
          state_next     = S_VIS_RD;
        end
      end
      S_VIS_RD: begin
        ctl.vis_issue = 1'b1;
        state_next    = S_VIS_CHK;
      end
      S_VIS_CHK: begin
        if (stat.vis_hit) begin
          state_next = S_POP_CHECK;
        end else begin
          ctl.vis_mark = 1'b1;
          if (stat.at_target) begin
            ctl.res_set  = 1'b1;
            ctl.res_code = ST_FOUND;
            state_next   = S_FINISH;
          end else begin
            ctl.nb_first = 1'b1;
            state_next   = S_NB_X;
          end
        end
      end
      // neighbour scan
      S_NB_X: begin
        ctl.nb_x_eval = 1'b1;
        if (stat.nb_ok) begin
          state_next = S_NB_Y;
        end else if (stat.nb_last) begin
          state_next = S_POP_CHECK;
        end else begin
          ctl.nb_next = 1'b1;
        end
      end
      S_NB_Y: begin
        ctl.nb_y_eval = 1'b1;
        state_next    = S_NB_EVAL;
      end
      S_NB_EVAL: begin
        if (stat.vis_hit) begin
          if (stat.nb_last) begin
            state_next = S_POP_CHECK;
          end else begin
            ctl.nb_next = 1'b1;
            state_next  = S_NB_X;
          end
        end else if (stat.heap_full) begin
          ctl.res_set  = 1'b1;
          ctl.res_code = ST_OVERFLOW;
          state_next   = S_FINISH;
        end else begin
          ctl.push_start = 1'b1;
          state_next     = S_PUSH_LOOP;
        end
      end
      // sift the new entry up
      S_PUSH_LOOP: begin
        if (stat.push_at_root) begin
          ctl.hole_place = 1'b1;
          if (stat.nb_last) begin
            state_next = S_POP_CHECK;
          end else begin
            ctl.nb_next = 1'b1;
            state_next  = S_NB_X;
          end
        end else begin
          ctl.push_issue = 1'b1;
          state_next     = S_PUSH_WAIT;
        end
      end
      S_PUSH_WAIT: begin
        if (stat.push_go) begin
          ctl.push_move = 1'b1;
          state_next    = S_PUSH_LOOP;
        end else begin
          ctl.hole_place = 1'b1;
          if (stat.nb_last) begin
            state_next = S_POP_CHECK;
          end else begin
            ctl.nb_next = 1'b1;
            state_next  = S_NB_X;
          end
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/tgsp_dpath.sv =====
// Datapath: config, grid store, visited map, binary heap and result register.
module tgsp_dpath
  import tgsp_pkg::*;
#(
  parameter int HEAP_DEPTH = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [COORD_IN_W-1:0]   cell_x,
  input  logic [COORD_IN_W-1:0]   cell_y,
  input  logic [DIGIT_W-1:0]      cell_cost,
  input  logic                    out_stall,
  input  ctl_cmd_t                ctl,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic [COST_W-1:0]       path_cost,
  output logic [STAT_W-1:0]       status
);

  localparam int SIDE_MAX = MAX_SIZE * MAX_TILES;
  localparam int CW       = $clog2(SIDE_MAX);
  localparam int SW       = $clog2(SIDE_MAX + 1);
  localparam int GS_W     = $clog2(MAX_SIZE + 1);
  localparam int TC_W     = $clog2(MAX_TILES + 1);
  localparam int MW       = $clog2(MAX_SIZE);
  localparam int GDEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int GA_W     = $clog2(GDEPTH);
  localparam int VDEPTH   = SIDE_MAX * SIDE_MAX;
  localparam int VA_W     = $clog2(VDEPTH);
  localparam int HP_W     = $clog2(HEAP_DEPTH);
  localparam int HC_W     = $clog2(HEAP_DEPTH + 1);

  // neighbour order: west, east, north, south
  localparam logic [1:0] DIR_WEST  = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_SOUTH = 2'd3;

  typedef struct packed {
    logic [CW-1:0]     x;
    logic [CW-1:0]     y;
    logic [COST_W-1:0] cost;
  } entry_t;

  // Configuration registers
  logic [GS_CFG_W-1:0] grid_size;
  logic [TC_CFG_W-1:0] tile_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= GS_CFG_W'(32);
      tile_count <= TC_CFG_W'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SIZE:  grid_size  <= cfg_data;
        REG_TILE_COUNT: tile_count <= cfg_data[TC_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry, latched when a run starts
  logic [GS_W-1:0] gs_eff;
  logic [TC_W-1:0] tc_eff;
  logic [SW-1:0]   bound [MAX_TILES];
  logic [CW-1:0]   last;

  always_comb begin
    if (grid_size == '0)                 gs_eff = GS_W'(1);
    else if (int'(grid_size) > MAX_SIZE) gs_eff = GS_W'(MAX_SIZE);
    else                                 gs_eff = GS_W'(grid_size);
    if (tile_count == '0)                 tc_eff = TC_W'(1);
    else if (int'(tile_count) > MAX_TILES) tc_eff = TC_W'(MAX_TILES);
    else                                  tc_eff = TC_W'(tile_count);
  end

  always_ff @(posedge clk) begin
    if (ctl.run_start) begin
      for (int k = 0; k < MAX_TILES; k++) begin
        bound[k] <= SW'(k) * SW'(gs_eff);
      end
      last <= CW'(SW'(tc_eff) * SW'(gs_eff) - SW'(1));
    end
  end

  // Current popped entry, hole register and neighbour index
  entry_t          cur;
  entry_t          hole;
  logic [HP_W-1:0] pos;
  logic [HC_W-1:0] count;
  logic [1:0]      nb_idx;
  logic [CW-1:0]   nb_x, nb_y;
  logic [MW-1:0]   mx;
  logic [TC_W-1:0] tx, ty;

  // Neighbour coordinates and range check
  logic [CW-1:0] nx_c, ny_c;
  logic          nb_ok_c;

  always_comb begin
    nx_c    = cur.x;
    ny_c    = cur.y;
    nb_ok_c = 1'b0;
    case (nb_idx)
      DIR_WEST: begin
        nx_c    = cur.x - CW'(1);
        nb_ok_c = cur.x != '0;
      end
      DIR_EAST: begin
        nx_c    = cur.x + CW'(1);
        nb_ok_c = cur.x != last;
      end
      DIR_NORTH: begin
        ny_c    = cur.y - CW'(1);
        nb_ok_c = cur.y != '0;
      end
      DIR_SOUTH: begin
        ny_c    = cur.y + CW'(1);
        nb_ok_c = cur.y != last;
      end
      default: ;
    endcase
  end

  // Tile split: tile index and offset in base grid, shared by both axes
  logic [CW-1:0]   tu_in;
  logic [SW-1:0]   tu_rem;
  logic [TC_W-1:0] tu_tile;

  assign tu_in = ctl.nb_x_eval ? nx_c : nb_y;

  always_comb begin
    tu_rem  = SW'(tu_in);
    tu_tile = '0;
    for (int k = 0; k < MAX_TILES; k++) begin
      if (SW'(tu_in) >= bound[k]) begin
        tu_rem  = SW'(tu_in) - bound[k];
        tu_tile = TC_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.nb_first) nb_idx <= DIR_WEST;
    else if (ctl.nb_next) nb_idx <= nb_idx + 2'd1;
    if (ctl.nb_x_eval) begin
      nb_x <= nx_c;
      nb_y <= ny_c;
      mx   <= MW'(tu_rem);
      tx   <= tu_tile;
    end
    if (ctl.nb_y_eval) ty <= tu_tile;
  end

  // Grid store
  logic [DIGIT_W-1:0] gmem [GDEPTH];
  logic [DIGIT_W-1:0] grid_rd;
  logic               load_ok;
  logic [GA_W-1:0]    g_waddr, g_raddr;

  assign load_ok = (int'(cell_x) < MAX_SIZE) && (int'(cell_y) < MAX_SIZE);
  assign g_waddr = GA_W'(cell_y) * GA_W'(MAX_SIZE) + GA_W'(cell_x);
  assign g_raddr = GA_W'(MW'(tu_rem)) * GA_W'(MAX_SIZE) + GA_W'(mx);

  always_ff @(posedge clk) begin
    if (ctl.load_cell && load_ok) gmem[g_waddr] <= cell_cost;
    if (ctl.nb_y_eval) grid_rd <= gmem[g_raddr];
  end

  // Visited map, cleared by a sweep at the start of each run
  logic            vmem [VDEPTH];
  logic            vis_rd;
  logic [VA_W-1:0] clr_addr;
  logic [VA_W-1:0] cur_vaddr, nb_vaddr, v_waddr, v_raddr;
  logic            v_we, v_wdata;

  assign cur_vaddr = VA_W'(cur.y) * VA_W'(SIDE_MAX) + VA_W'(cur.x);
  assign nb_vaddr  = VA_W'(ny_c) * VA_W'(SIDE_MAX) + VA_W'(nx_c);
  assign v_we      = ctl.clr_step | ctl.vis_mark;
  assign v_waddr   = ctl.clr_step ? clr_addr : cur_vaddr;
  assign v_wdata   = ctl.vis_mark;
  assign v_raddr   = ctl.vis_issue ? cur_vaddr : nb_vaddr;

  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    if (ctl.vis_issue || ctl.nb_x_eval) vis_rd <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.run_start)     clr_addr <= '0;
    else if (ctl.clr_step) clr_addr <= clr_addr + VA_W'(1);
  end

  // Heap store: one write port, two registered read ports
  entry_t          hmem [HEAP_DEPTH];
  entry_t          rd_a, rd_b;
  logic [HP_W-1:0] ra_addr, rb_addr, h_waddr;
  entry_t          h_wdata;
  logic            h_re_a, h_re_b, h_we;
  logic [HC_W:0]   child, child_b;
  logic            pick_b;
  entry_t          sel;
  logic [HP_W-1:0] sel_addr, parent;
  logic [COST_W-1:0] step_cost;

  assign child    = (HC_W+1)'(pos) * (HC_W+1)'(2) + (HC_W+1)'(1);
  assign child_b  = child + (HC_W+1)'(1);
  assign pick_b   = (child_b < (HC_W+1)'(count)) && (rd_b.cost < rd_a.cost);
  assign sel      = pick_b ? rd_b : rd_a;
  assign sel_addr = pick_b ? HP_W'(child_b) : HP_W'(child);
  assign parent   = (pos - HP_W'(1)) >> 1;
  assign step_cost = COST_W'(mod9_inc(6'(grid_rd) + 6'd8 + 6'(tx) + 6'(ty)));

  always_comb begin
    ra_addr = '0;
    rb_addr = HP_W'(count - HC_W'(1));
    h_re_a  = ctl.pop_issue | ctl.sift_issue | ctl.push_issue;
    h_re_b  = ctl.pop_issue | ctl.sift_issue;
    if (ctl.sift_issue) begin
      ra_addr = HP_W'(child);
      rb_addr = HP_W'(child_b);
    end else if (ctl.push_issue) begin
      ra_addr = parent;
    end
    h_we    = ctl.heap_init | ctl.hole_place | ctl.sift_move | ctl.push_move;
    h_waddr = ctl.heap_init ? '0 : pos;
    if (ctl.sift_move)      h_wdata = sel;
    else if (ctl.push_move) h_wdata = rd_a;
    else if (ctl.heap_init) h_wdata = '0;
    else                    h_wdata = hole;
  end

  always_ff @(posedge clk) begin
    if (h_we)   hmem[h_waddr] <= h_wdata;
    if (h_re_a) rd_a <= hmem[ra_addr];
    if (h_re_b) rd_b <= hmem[rb_addr];
  end

  // Heap count
  always_ff @(posedge clk) begin
    if (rst)                 count <= '0;
    else if (ctl.heap_init)  count <= HC_W'(1);
    else if (ctl.pop_issue)  count <= count - HC_W'(1);
    else if (ctl.push_start) count <= count + HC_W'(1);
  end

  // Hole position and carried entry
  always_ff @(posedge clk) begin
    if (ctl.pop_first) begin
      cur  <= rd_a;
      hole <= rd_b;
      pos  <= '0;
    end else if (ctl.push_start) begin
      hole.x    <= nb_x;
      hole.y    <= nb_y;
      hole.cost <= cur.cost + step_cost;
      pos       <= HP_W'(count);
    end else if (ctl.sift_move) begin
      pos <= sel_addr;
    end else if (ctl.push_move) begin
      pos <= parent;
    end
  end

  // Result and output register
  logic [COST_W-1:0] res_cost;
  status_t           res_status;

  always_ff @(posedge clk) begin
    if (ctl.res_set) begin
      res_status <= ctl.res_code;
      res_cost   <= (ctl.res_code == ST_FOUND) ? cur.cost : '0;
    end
    if (ctl.out_load) begin
      path_cost <= res_cost;
      status    <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (ctl.out_load) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

  // Status back to the controller
  always_comb begin
    stat.clr_last       = clr_addr == VA_W'(VDEPTH - 1);
    stat.heap_empty     = count == '0;
    stat.heap_full      = count == HC_W'(HEAP_DEPTH);
    stat.sift_has_child = child < (HC_W+1)'(count);
    stat.sift_go        = sel.cost < hole.cost;
    stat.push_at_root   = pos == '0;
    stat.push_go        = hole.cost < rd_a.cost;
    stat.vis_hit        = vis_rd;
    stat.at_target      = (cur.x == last) && (cur.y == last);
    stat.nb_ok          = nb_ok_c;
    stat.nb_last        = nb_idx == DIR_SOUTH;
    stat.out_free       = !out_valid || !out_stall;
  end

endmodule

// ===== sv/tiled_grid_shortest_path_core.sv =====
// Top level of the tiled grid shortest path block.
// Load request: accepted one per cycle back to back while no run is in progress, no result.
// Run request: a visited-map clearing sweep over (MAX_SIZE*MAX_TILES)^2 entries, then for
// each popped heap entry a sift down from the root, for each pushed neighbour a sift up;
// no new request is taken until the run has handed its result to the output register.
// The result passes the result and output registers; heap port and sift loop set the rate.
// Synchronous active-high reset clears control, heap count and config to 32 and 5.
module tiled_grid_shortest_path_core
  import tgsp_pkg::*;
#(
  parameter int HEAP_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [COORD_IN_W-1:0] cell_x,
  input  logic [COORD_IN_W-1:0] cell_y,
  input  logic [DIGIT_W-1:0]    cell_cost,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COST_W-1:0]     path_cost,
  output logic [STAT_W-1:0]     status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  tgsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat),
    .ctl      (ctl)
  );

  tgsp_dpath #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cell_cost (cell_cost),
    .out_stall (out_stall),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .path_cost (path_cost),
    .status    (status)
  );

endmodule

// ===== sim/tgsp_checker.sv =====
// Checker for the tiled grid shortest path block: predicts run results and compares them.
module tgsp_checker
  import tgsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  cmd,
  input  logic [COORD_IN_W-1:0] cell_x,
  input  logic [COORD_IN_W-1:0] cell_y,
  input  logic [DIGIT_W-1:0]    cell_cost,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COST_W-1:0]     path_cost,
  input  logic [STAT_W-1:0]     status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    pending
);

  localparam int GRID_MAX  = 32;
  localparam int TILES_MAX = 5;
  localparam int HEAP_MAX  = 4096;
  localparam int SIDE_MAX  = GRID_MAX * TILES_MAX;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    status_t           st;
  } route_t;

  // Shadow state of the block
  logic [DIGIT_W-1:0]  digits [GRID_MAX][GRID_MAX];
  logic [GS_CFG_W-1:0] grid_reg;
  logic [TC_CFG_W-1:0] tile_reg;
  route_t              routes_due[$];

  // Frontier heap and visited map of the predictor
  int frontier_x [HEAP_MAX];
  int frontier_y [HEAP_MAX];
  int frontier_c [HEAP_MAX];
  int frontier_n;
  bit seen [SIDE_MAX*SIDE_MAX];

  assign pending = routes_due.size();

  function automatic void frontier_swap(int a, int b);
    int tx, ty, tcst;
    tx = frontier_x[a]; ty = frontier_y[a]; tcst = frontier_c[a];
    frontier_x[a] = frontier_x[b]; frontier_y[a] = frontier_y[b]; frontier_c[a] = frontier_c[b];
    frontier_x[b] = tx; frontier_y[b] = ty; frontier_c[b] = tcst;
  endfunction

  function automatic bit frontier_push(int x, int y, int c);
    int pos, up;
    if (frontier_n >= HEAP_MAX) return 1'b0;
    pos = frontier_n;
    frontier_n++;
    frontier_x[pos] = x; frontier_y[pos] = y; frontier_c[pos] = c;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(frontier_c[pos] < frontier_c[up])) break;
      frontier_swap(pos, up);
      pos = up;
    end
    return 1'b1;
  endfunction

  function automatic void frontier_pop(output int x, output int y, output int c);
    int pos, child;
    x = frontier_x[0]; y = frontier_y[0]; c = frontier_c[0];
    pos = 0;
    frontier_n--;
    frontier_x[0] = frontier_x[frontier_n];
    frontier_y[0] = frontier_y[frontier_n];
    frontier_c[0] = frontier_c[frontier_n];
    while (pos * 2 + 1 < frontier_n) begin
      child = pos * 2 + 1;
      if (child + 1 < frontier_n && frontier_c[child+1] < frontier_c[child]) child++;
      if (!(frontier_c[child] < frontier_c[pos])) break;
      frontier_swap(pos, child);
      pos = child;
    end
  endfunction

  // Dijkstra over the tiled grid, same heap discipline as the block
  function automatic route_t shortest_route();
    route_t r;
    int gs, tc, side, last, x, y, c, nx, ny, d, step;
    int dx [4];
    int dy [4];
    dx = '{-1, 1, 0, 0};
    dy = '{0, 0, -1, 1};
    gs = (grid_reg == 0) ? 1 : ((grid_reg > GRID_MAX) ? GRID_MAX : int'(grid_reg));
    tc = (tile_reg == 0) ? 1 : ((tile_reg > TILES_MAX) ? TILES_MAX : int'(tile_reg));
    side = gs * tc;
    last = side - 1;
    foreach (seen[i]) seen[i] = 1'b0;
    frontier_n = 0;
    r.cost = '0;
    r.st = ST_EMPTY;
    void'(frontier_push(0, 0, 0));
    while (frontier_n > 0) begin
      frontier_pop(x, y, c);
      if (seen[y*SIDE_MAX+x]) continue;
      seen[y*SIDE_MAX+x] = 1'b1;
      if (x == last && y == last) begin
        r.cost = COST_W'(c);
        r.st = ST_FOUND;
        return r;
      end
      for (d = 0; d < 4; d++) begin
        nx = x + dx[d];
        ny = y + dy[d];
        if (nx < 0 || ny < 0 || nx >= side || ny >= side) continue;
        if (seen[ny*SIDE_MAX+nx]) continue;
        step = ((int'(digits[ny%gs][nx%gs]) + 8 + nx/gs + ny/gs) % 9) + 1;
        if (!frontier_push(nx, ny, c + step)) begin
          r.st = ST_OVERFLOW;
          return r;
        end
      end
    end
    return r;
  endfunction

  // Track requests, configuration and results
  always @(posedge clk) begin
    route_t want;
    if (rst) begin
      grid_reg = 6'd32;
      tile_reg = 3'd5;
      routes_due.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_SIZE) grid_reg = cfg_data;
        else if (cfg_index == REG_TILE_COUNT) tile_reg = cfg_data[TC_CFG_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (routes_due.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result: cost %0d status %0d", path_cost, status);
        end else begin
          want = routes_due.pop_front();
          if (path_cost !== want.cost || status !== want.st) begin
            fails++;
            if (fails <= 10)
              $display("result mismatch: expected cost %0d status %0d, got cost %0d status %0d",
                       want.cost, want.st, path_cost, status);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_LOAD) digits[cell_y][cell_x] = cell_cost;
        else routes_due.push_back(shortest_route());
      end
    end
  end

endmodule

// ===== sim/tb_tiled_grid_shortest_path_core.sv =====
// Testbench top: stimulus, stalls, watchdog and verdict for the shortest path block.
module tb_tiled_grid_shortest_path_core;
  import tgsp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam int WATCHDOG = 2000000;
  localparam int PHASES   = 8;

  logic                  clk, rst;
  logic                  in_valid, in_stall, cmd;
  logic [COORD_IN_W-1:0] cell_x, cell_y;
  logic [DIGIT_W-1:0]    cell_cost;
  logic                  out_valid, out_stall;
  logic [COST_W-1:0]     path_cost;
  logic [STAT_W-1:0]     status;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails, pending;
  int                    idle_cycles;
  int                    hold_ask, hold_done, hold_left;
  bit                    calm;
  bit                    loaded [32][32];

  tiled_grid_shortest_path_core u_top (.*);

  tgsp_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random gap: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_ask) begin
      hold_done <= hold_ask;
      hold_left <= 60000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_request(logic c, int x, int y, int d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    cell_x    <= COORD_IN_W'(x);
    cell_y    <= COORD_IN_W'(y);
    cell_cost <= DIGIT_W'(d);
    if (c == CMD_LOAD) loaded[y][x] = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic load_cell(int x, int y, int d);
    send_request(CMD_LOAD, x, y, d);
  endtask

  task automatic run_search();
    send_request(CMD_RUN, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15));
  endtask

  // Let every outstanding result come back, then idle a little
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Make sure every base cell a run can read has been loaded
  task automatic fill_grid(int gs);
    for (int y = 0; y < gs; y++)
      for (int x = 0; x < gs; x++)
        if (!loaded[y][x]) load_cell(x, y, $urandom_range(0, 15));
  endtask

  initial begin
    int gs_set [PHASES];
    int tc_set [PHASES];
    int gs;
    gs_set = '{1, 2, 0, 5, 3, 8, 6, 4};
    tc_set = '{1, 5, 0, 2, 7, 1, 3, 1};
    in_valid = 1'b0; cmd = CMD_LOAD; cell_x = '0; cell_y = '0; cell_cost = '0;
    cfg_valid = 1'b0; cfg_index = REG_GRID_SIZE; cfg_data = '0;
    hold_ask = 0;
    calm = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: digit and coordinate extremes, unused registers, single cell
    write_reg(REG_SPARE, 63);
    write_reg(REG_SPARE_LO, 0);
    load_cell(31, 31, 15);
    load_cell(0, 31, 0);
    load_cell(31, 0, 9);
    load_cell(0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_reg(REG_GRID_SIZE, gs_set[p]);
      write_reg(REG_TILE_COUNT, tc_set[p]);
      gs = (gs_set[p] == 0) ? 1 : ((gs_set[p] > 32) ? 32 : gs_set[p]);
      calm = (p % 3 == 2);
      fill_grid(gs);
      run_search();
      // Long receiver hold-off while loads keep coming
      if (p == 1) begin
        hold_ask++;
        run_search();
      end
      for (int i = 0; i < 58; i++) begin
        if ($urandom_range(0, 99) < ((gs > 8) ? 1 : 5)) run_search();
        else if ($urandom_range(0, 1) == 0)
          load_cell($urandom_range(0, gs - 1), $urandom_range(0, gs - 1), $urandom_range(0, 15));
        else load_cell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15));
      end
      run_search();
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
